// File: sv/tvs_pkg.sv
// ----------------------------------------------------------------------------
// tvs_pkg
// Shared widths, types, register indexes and blend helpers for the
// trilinear volume sampler.
// ----------------------------------------------------------------------------
package tvs_pkg;

	localparam int FRAC_BITS   = 8;
	localparam int SAMPLE_BITS = 16;
	localparam int DIM_BITS    = 11;
	localparam int COORD_BITS  = DIM_BITS + FRAC_BITS;
	localparam int OUT_BITS    = SAMPLE_BITS + FRAC_BITS;
	localparam int CFG_IDX_BITS = 2;

	typedef logic signed [COORD_BITS-1:0]  coord_t;
	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [OUT_BITS-1:0]    out_t;
	typedef logic        [DIM_BITS-1:0]    dim_t;
	typedef logic        [FRAC_BITS-1:0]   weight_t;
	typedef logic        [CFG_IDX_BITS-1:0] cfg_idx_t;

	// configuration register indexes
	localparam cfg_idx_t CFG_DIM_X = 2'd0;
	localparam cfg_idx_t CFG_DIM_Y = 2'd1;
	localparam cfg_idx_t CFG_DIM_Z = 2'd2;

	localparam dim_t DIM_RESET = DIM_BITS'(256);

	typedef struct packed {
		dim_t dim_x;
		dim_t dim_y;
		dim_t dim_z;
	} dims_t;

	// (1-w)*a + w*b on raw samples, written as a*2^F + w*(b-a); keeps F fraction bits
	function automatic out_t lerp_x(input sample_t a, input sample_t b, input weight_t w);
		logic signed [SAMPLE_BITS:0]             d;
		logic signed [SAMPLE_BITS+FRAC_BITS+1:0] p;
		logic signed [SAMPLE_BITS+FRAC_BITS+1:0] s;
		d = $signed({b[SAMPLE_BITS-1], b}) - $signed({a[SAMPLE_BITS-1], a});
		p = d * $signed({1'b0, w});
		s = p + $signed({{2{a[SAMPLE_BITS-1]}}, a, {FRAC_BITS{1'b0}}});
		return s[OUT_BITS-1:0];
	endfunction

	// same blend on F-fraction values, low F bits dropped (floor)
	function automatic out_t lerp_yz(input out_t a, input out_t b, input weight_t w);
		logic signed [OUT_BITS:0]             d;
		logic signed [OUT_BITS+FRAC_BITS+1:0] p;
		logic signed [OUT_BITS+FRAC_BITS+1:0] s;
		d = $signed({b[OUT_BITS-1], b}) - $signed({a[OUT_BITS-1], a});
		p = d * $signed({1'b0, w});
		s = p + $signed({{2{a[OUT_BITS-1]}}, a, {FRAC_BITS{1'b0}}});
		return s[OUT_BITS+FRAC_BITS-1:FRAC_BITS];
	endfunction

endpackage

// File: sv/trilinear_volume_sampler.sv
// ----------------------------------------------------------------------------
// trilinear_volume_sampler
// Trilinear blend of eight voxel values at a fixed-point sample point,
// with a bound test of the base cell against the configured volume size.
// ----------------------------------------------------------------------------
// Stages: x, y and z blend stages, each registered, lie between input beat and output beat.
// Throughput: one beat per cycle while out_ready is high; each stage has its own multiplier lane
// per blend, and a stalled stage holds while empty stages upstream still fill.
// Reset: arst_n clears all stage valids and sets dim_x/y/z to 256.
// ----------------------------------------------------------------------------
module trilinear_volume_sampler (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration
	input  logic                      cfg_we,
	input  tvs_pkg::cfg_idx_t         cfg_index,
	input  tvs_pkg::dim_t             cfg_data,
	// input channel
	input  logic                      in_valid,
	output logic                      in_ready,
	input  tvs_pkg::coord_t           coord_x,
	input  tvs_pkg::coord_t           coord_y,
	input  tvs_pkg::coord_t           coord_z,
	input  tvs_pkg::sample_t          corner_000,
	input  tvs_pkg::sample_t          corner_100,
	input  tvs_pkg::sample_t          corner_010,
	input  tvs_pkg::sample_t          corner_110,
	input  tvs_pkg::sample_t          corner_001,
	input  tvs_pkg::sample_t          corner_101,
	input  tvs_pkg::sample_t          corner_011,
	input  tvs_pkg::sample_t          corner_111,
	// output channel
	output logic                      out_valid,
	input  logic                      out_ready,
	output tvs_pkg::out_t             sample_value,
	output logic                      in_range
);
	import tvs_pkg::*;

	// volume size registers
	dims_t dims_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q.dim_x <= DIM_RESET;
			dims_q.dim_y <= DIM_RESET;
			dims_q.dim_z <= DIM_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DIM_X: dims_q.dim_x <= cfg_data;
				CFG_DIM_Y: dims_q.dim_y <= cfg_data;
				CFG_DIM_Z: dims_q.dim_z <= cfg_data;
				default: ;	// unmapped index, write dropped
			endcase
		end
	end

	// bound test on the incoming beat
	logic ok_in;

	tvs_bounds u_bounds (
		.coord_x (coord_x),
		.coord_y (coord_y),
		.coord_z (coord_z),
		.dims    (dims_q),
		.ok      (ok_in)
	);

	// stage handshake: a stage takes a new beat when empty or when it drains
	logic v_s1, v_s2, v_s3;
	logic rdy_s1, rdy_s2, rdy_s3;

	assign rdy_s3   = !v_s3 || out_ready;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	// stage 1: blend along x, four lanes
	out_t    x00_s1, x10_s1, x01_s1, x11_s1;
	weight_t wy_s1, wz_s1;
	logic    ok_s1;

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			x00_s1 <= lerp_x(corner_000, corner_100, coord_x[FRAC_BITS-1:0]);
			x10_s1 <= lerp_x(corner_010, corner_110, coord_x[FRAC_BITS-1:0]);
			x01_s1 <= lerp_x(corner_001, corner_101, coord_x[FRAC_BITS-1:0]);
			x11_s1 <= lerp_x(corner_011, corner_111, coord_x[FRAC_BITS-1:0]);
			wy_s1  <= coord_y[FRAC_BITS-1:0];
			wz_s1  <= coord_z[FRAC_BITS-1:0];
			ok_s1  <= ok_in;
		end
	end

	// stage 2: blend along y, two lanes, floor back to F fraction bits
	out_t    y0_s2, y1_s2;
	weight_t wz_s2;
	logic    ok_s2;

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			y0_s2 <= lerp_yz(x00_s1, x10_s1, wy_s1);
			y1_s2 <= lerp_yz(x01_s1, x11_s1, wy_s1);
			wz_s2 <= wz_s1;
			ok_s2 <= ok_s1;
		end
	end

	// stage 3: blend along z; out-of-range beats forced to zero here
	out_t res_s3;
	logic ok_s3;

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			res_s3 <= ok_s2 ? lerp_yz(y0_s2, y1_s2, wz_s2) : '0;
			ok_s3  <= ok_s2;
		end
	end

	assign out_valid    = v_s3;
	assign sample_value = res_s3;
	assign in_range     = ok_s3;

endmodule

// File: sv/tvs_bounds.sv
// ----------------------------------------------------------------------------
// tvs_bounds
// Base cell test: 0 <= floor(coord) < dim - 1 on all three axes.
// ----------------------------------------------------------------------------
module tvs_bounds (
	input  tvs_pkg::coord_t coord_x,
	input  tvs_pkg::coord_t coord_y,
	input  tvs_pkg::coord_t coord_z,
	input  tvs_pkg::dims_t  dims,
	output logic            ok
);
	import tvs_pkg::*;

	logic ok_x, ok_y, ok_z;

	// base + 1 < dim avoids the wrap of dim - 1 when dim is zero
	function automatic logic axis_ok(input coord_t c, input dim_t d);
		logic [DIM_BITS-1:0] b1;
		b1 = {1'b0, c[COORD_BITS-2:FRAC_BITS]} + DIM_BITS'(1);
		return !c[COORD_BITS-1] && (b1 < d);
	endfunction

	always_comb begin
		ok_x = axis_ok(coord_x, dims.dim_x);
		ok_y = axis_ok(coord_y, dims.dim_y);
		ok_z = axis_ok(coord_z, dims.dim_z);
		ok   = ok_x && ok_y && ok_z;
	end

endmodule
